>>> src/rleb_pkg.sv
package rleb_pkg;

	localparam logic [7:0]  DigitLo    = 8'd47;
	localparam logic [7:0]  DigitHi    = 8'd58;
	localparam logic [7:0]  DigitOne   = 8'd20;
	localparam logic [7:0]  DigitTwo   = 8'd10;
	localparam logic [7:0]  OtherTwo   = 8'd32;
	localparam logic [7:0]  CountTen   = 8'd126;
	localparam logic [7:0]  NewlineB   = 8'd10;
	localparam logic [15:0] LenTen     = 16'd10;
	localparam logic [15:0] LenMax     = 16'hFFFF;
	localparam int          MaxResults = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} rleb_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} rleb_out_t;

	// code bytes for one closed run
	typedef struct packed {
		logic       sym_v;
		logic [7:0] sym_code;
		logic       cnt_v;
		logic [7:0] cnt_code;
	} rleb_code_t;

	function automatic rleb_code_t run_code(input logic [7:0] sym, input logic [15:0] len);
		rleb_code_t c;
		logic       digit;
		digit      = (sym > DigitLo) && (sym < DigitHi);
		c.sym_v    = (len != 16'd0);
		c.cnt_v    = (len > 16'd2);
		if (len == 16'd1) begin
			c.sym_code = digit ? sym - DigitOne : sym;
		end else begin
			c.sym_code = digit ? sym - DigitTwo : sym + OtherTwo;
		end
		c.cnt_code = (len == LenTen) ? CountTen : len[7:0];
		return c;
	endfunction

endpackage

>>> src/run_length_byte_encoder_top.sv
// an accepted beat's results go to the result buffer, then to the output register
// throughput: one input beat per cycle while the result buffer is empty; a beat with
// results holds the input until its last byte leaves, one byte a cycle unless out_stall
// reset: arst_n clears the open run and empties the result buffer and the output register
module run_length_byte_encoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  rleb_pkg::rleb_in_t  src_beat,
	output logic              out_valid,
	input  logic              out_stall,
	output rleb_pkg::rleb_out_t out_beat
);
	import rleb_pkg::*;

	logic [7:0]  sym_q;
	logic [15:0] len_q;

	logic [7:0] buf_q [MaxResults];
	logic [2:0] cnt_q;
	logic [1:0] rd_q;

	logic       out_valid_q;
	rleb_out_t  out_q;

	logic        accept;
	logic        move;
	logic        rd_is_end;
	logic        cont;
	logic [7:0]  new_sym;
	logic [15:0] new_len;
	rleb_code_t  old_code;
	rleb_code_t  new_code;
	logic [7:0]  cand_b [5];
	logic        cand_v [5];
	logic [7:0]  res_b [MaxResults];
	logic [2:0]  res_n;

	assign rd_is_end = ({1'b0, rd_q} + 3'd1) == cnt_q;
	assign move      = (cnt_q != 3'd0) && (!out_valid_q || !out_stall);
	// buffer may take a new list when it is empty or its final byte leaves now
	assign src_stall = !((cnt_q == 3'd0) || (move && rd_is_end));
	assign accept    = src_valid && !src_stall;

	always_comb begin
		cont     = (len_q != 16'd0) && (sym_q == src_beat.in_byte);
		old_code = run_code(sym_q, len_q);
		if (cont) begin
			new_sym = sym_q;
			new_len = (len_q == LenMax) ? len_q : len_q + 16'd1;
		end else begin
			new_sym = src_beat.in_byte;
			new_len = 16'd1;
		end
		new_code = run_code(new_sym, new_len);
	end

	always_comb begin
		cand_v[0] = !cont && old_code.sym_v;
		cand_b[0] = old_code.sym_code;
		cand_v[1] = !cont && old_code.cnt_v;
		cand_b[1] = old_code.cnt_code;
		cand_v[2] = src_beat.in_last && new_code.sym_v;
		cand_b[2] = new_code.sym_code;
		cand_v[3] = src_beat.in_last && new_code.cnt_v;
		cand_b[3] = new_code.cnt_code;
		cand_v[4] = src_beat.in_last;
		cand_b[4] = NewlineB;
	end

	// pack the valid candidates in order, at most four of them
	always_comb begin
		res_n = 3'd0;
		for (int i = 0; i < MaxResults; i++) begin
			res_b[i] = 8'd0;
		end
		for (int i = 0; i < 5; i++) begin
			if (cand_v[i]) begin
				res_b[res_n[1:0]] = cand_b[i];
				res_n = res_n + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= 8'd0;
			len_q <= 16'd0;
		end else if (accept) begin
			if (src_beat.in_last) begin
				sym_q <= 8'd0;
				len_q <= 16'd0;
			end else begin
				sym_q <= new_sym;
				len_q <= new_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q  <= 2'd0;
		end else begin
			if (move) begin
				if (rd_is_end) begin
					cnt_q <= 3'd0;
					rd_q  <= 2'd0;
				end else begin
					rd_q <= rd_q + 2'd1;
				end
			end
			if (accept && (res_n != 3'd0)) begin
				cnt_q <= res_n;
				rd_q  <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (res_n != 3'd0)) begin
			for (int i = 0; i < MaxResults; i++) begin
				buf_q[i] <= res_b[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.out_byte <= buf_q[rd_q];
			out_q.out_last <= rd_is_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

endmodule

>>> src/rleb_checker.sv
module rleb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_stall,
	input rleb_pkg::rleb_in_t  src_beat,
	input logic              out_valid,
	input logic              out_stall,
	input rleb_pkg::rleb_out_t out_beat
);
	import rleb_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("result beat changed while stalled");

	// output register is empty right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// input only stalls while results are pending, so output is busy next cycle
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |=> out_valid)
		else $error("input stalled with no pending result");

	// bytes of one list come out back to back
	a_list_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_beat.out_last |=> out_valid)
		else $error("gap inside a result list");

endmodule

bind run_length_byte_encoder_top rleb_checker u_rleb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_beat  (src_beat),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_beat  (out_beat)
);

>>> tb/sv/rle_code_checker.sv
module rle_code_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  logic                src_stall,
	input  rleb_pkg::rleb_in_t  src_beat,
	input  logic                out_valid,
	input  logic                out_stall,
	input  rleb_pkg::rleb_out_t out_beat,
	output int                  fail_count,
	output int                  pending,
	output int                  beats_in,
	output int                  bytes_out
);
	import rleb_pkg::*;

	localparam logic [7:0]  AsciiZero      = 8'd48;
	localparam logic [7:0]  AsciiNine      = 8'd57;
	localparam logic [7:0]  DigitSingleOff = 8'd20;
	localparam logic [7:0]  DigitPairOff   = 8'd10;
	localparam logic [7:0]  OtherPairOff   = 8'd32;
	localparam logic [7:0]  TenRunCount    = 8'd126;
	localparam logic [7:0]  LineFeed       = 8'd10;
	localparam logic [15:0] RunTen         = 16'd10;
	localparam logic [15:0] RunCeiling     = 16'hFFFF;

	logic [7:0]  run_sym;
	logic [15:0] run_len;
	rleb_out_t   codes_due[$];
	rleb_out_t   step_codes[$];
	rleb_out_t   tail;
	rleb_out_t   want;

	function automatic void push_code(input logic [7:0] b);
		rleb_out_t r;
		r.out_byte = b;
		r.out_last = 1'b0;
		step_codes.push_back(r);
	endfunction

	// emit the code of the run now open, if any
	function automatic void close_run();
		logic digit;
		digit = (run_sym >= AsciiZero) && (run_sym <= AsciiNine);
		if (run_len == 16'd0) begin
			return;
		end
		if (run_len == 16'd1) begin
			push_code(digit ? run_sym - DigitSingleOff : run_sym);
		end else begin
			push_code(digit ? run_sym - DigitPairOff : run_sym + OtherPairOff);
			if (run_len >= 16'd3) begin
				push_code((run_len == RunTen) ? TenRunCount : run_len[7:0]);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_sym = '0;
			run_len = '0;
			codes_due.delete();
			fail_count = 0;
			pending    = 0;
			beats_in   = 0;
			bytes_out  = 0;
		end else begin
			// predict first so a beat's codes are queued before any compare
			if (src_valid && !src_stall) begin
				step_codes.delete();
				if (run_len != 16'd0 && run_sym == src_beat.in_byte) begin
					if (run_len != RunCeiling) begin
						run_len = run_len + 16'd1;
					end
				end else begin
					close_run();
					run_sym = src_beat.in_byte;
					run_len = 16'd1;
				end
				if (src_beat.in_last) begin
					close_run();
					push_code(LineFeed);
					run_sym = '0;
					run_len = '0;
				end
				if (step_codes.size() > 0) begin
					tail = step_codes.pop_back();
					tail.out_last = 1'b1;
					step_codes.push_back(tail);
				end
				foreach (step_codes[i]) begin
					codes_due.push_back(step_codes[i]);
				end
				beats_in++;
			end
			if (out_valid && !out_stall) begin
				bytes_out++;
				if (codes_due.size() == 0) begin
					$error("unexpected code byte %0d (last %0b)", out_beat.out_byte,
						out_beat.out_last);
					fail_count++;
				end else begin
					want = codes_due.pop_front();
					if (out_beat.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, got %0d", want.out_byte,
							out_beat.out_byte);
						fail_count++;
					end
					if (out_beat.out_last !== want.out_last) begin
						$error("out_last: expected %0b, got %0b", want.out_last,
							out_beat.out_last);
						fail_count++;
					end
				end
			end
			pending = codes_due.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	import rleb_pkg::*;

	localparam int IdleLimit   = 1000;
	localparam int CycleCap    = 40000;
	localparam int HoldCycles  = 64;
	localparam int RandomBeats = 178;
	localparam int DrainCycles = 8;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	rleb_in_t  src_beat;
	logic      out_valid;
	logic      out_stall;
	rleb_out_t out_beat;

	int fail_count;
	int pending;
	int beats_in;
	int bytes_out;

	bit steady;
	bit hold_req;

	run_length_byte_encoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_beat  (src_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	rle_code_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_beat   (src_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat),
		.fail_count (fail_count),
		.pending    (pending),
		.beats_in   (beats_in),
		.bytes_out  (bytes_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// returns at the edge where the beat is taken
	task automatic send_beat(input logic [7:0] b, input logic l);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_beat  <= '{in_byte: b, in_last: l};
		@(posedge clk);
		while (src_stall) @(posedge clk);
	endtask

	task automatic send_run(input logic [7:0] b, input int len, input logic closes);
		for (int i = 0; i < len; i++) begin
			send_beat(b, closes && (i == len - 1));
		end
	endtask

	// stimulus and verdict
	initial begin
		int sent;
		int runs;
		int len;
		int waited;
		logic [7:0] sym;

		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_beat  <= '0;
		steady    = 1'b0;
		hold_req  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single symbols, digit borders, wrap of the pair code, zero byte
		send_run(8'd65, 1, 1'b1);
		send_run(8'd48, 1, 1'b1);
		send_run(8'd47, 1, 1'b0);
		send_run(8'd58, 1, 1'b0);
		send_run(8'd48, 1, 1'b0);
		send_run(8'd57, 2, 1'b0);
		send_run(8'd53, 3, 1'b0);
		send_run(8'd255, 2, 1'b0);
		send_run(8'd1, 1, 1'b0);
		send_run(8'd0, 1, 1'b0);
		send_run(8'd126, 1, 1'b1);
		// open run closed by a new symbol that is also the last beat
		send_run(8'd97, 3, 1'b0);
		send_run(8'd98, 1, 1'b1);
		// last beat continues the open run
		send_run(8'd99, 2, 1'b1);
		send_run(8'd55, 1, 1'b1);

		// count byte: ten and around ten
		steady = 1'b1;
		send_run(8'd122, 10, 1'b0);
		send_run(8'd121, 9, 1'b0);
		send_run(8'd120, 11, 1'b1);

		// random texts, receiver holds off once early on
		hold_req = 1'b1;
		sent = 0;
		while (sent < RandomBeats) begin
			steady = ($urandom_range(0, 3) == 0);
			runs = $urandom_range(1, 5);
			for (int r = 0; r < runs; r++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: sym = 8'($urandom_range(48, 57));
					4: sym = 8'($urandom_range(46, 59));
					5: sym = 8'($urandom_range(224, 255));
					6: sym = 8'($urandom_range(1, 12));
					default: sym = 8'($urandom_range(1, 255));
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: len = 1;
					6, 7: len = 2;
					8: len = $urandom_range(3, 4);
					default: len = $urandom_range(5, 12);
				endcase
				send_run(sym, len, r == runs - 1);
				sent += len;
			end
		end
		src_valid <= 1'b0;

		waited = 0;
		@(posedge clk);
		while (pending != 0 && waited < IdleLimit) begin
			@(posedge clk);
			waited++;
		end
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d input beats and %0d code bytes: digit and other symbols,",
			beats_in, bytes_out);
		$display("runs of one to a dozen beats, the ten-run count, random texts, long hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// receiver: random stall per beat, calm stretches, one long hold-off
	initial begin
		int n;
		int beat_no;
		bit calm;
		bit hold_done;

		out_stall <= 1'b0;
		beat_no   = 0;
		calm      = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (beat_no % 40 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			n = calm ? 0 : $urandom_range(0, 3);
			if (hold_req && !hold_done) begin
				n = HoldCycles;
				hold_done = 1'b1;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			beat_no++;
		end
	end

	// watchdog on cycles with no beat moving on either side
	initial begin
		int idle;
		int cycles;

		idle   = 0;
		cycles = 0;
		while (idle < IdleLimit && cycles < CycleCap) begin
			@(posedge clk);
			cycles++;
			if ((src_valid && !src_stall) || (out_valid && !out_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("timeout after %0d cycles, %0d codes outstanding", cycles, pending);
		$display("Regression FAIL");
		$finish;
	end

endmodule
